// ===== sv/fat12s_pkg.sv =====
`default_nettype none
package fat12s_pkg;

    localparam int FAT_BYTES      = 6144;
    localparam int CLUSTER_BYTES  = 512;
    localparam int MAX_SEGMENTS   = 64;
    localparam int SEG_LIMIT      = MAX_SEGMENTS * CLUSTER_BYTES;
    localparam int BANK_DEPTH     = FAT_BYTES / 2;
    localparam int BANK_AW        = $clog2(BANK_DEPTH);
    localparam int OFF_W          = BANK_AW + 1;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam logic [11:0] CHAIN_END     = 12'hFF8;
    localparam logic [31:0] DATA_BASE_RST = 32'd16896;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_READ = 1'b1;

    typedef enum logic [1:0] {
        STAT_SEG       = 2'd0,
        STAT_REJECT    = 2'd1,
        STAT_TOOLONG   = 2'd2,
        STAT_CHAIN_END = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_READ,
        CMD_REJECT,
        CMD_TOOLONG
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t   kind;
        logic [12:0] fat_idx;
        logic [7:0]  fat_byte;
        logic [11:0] cluster;
        logic [20:0] position;
        logic [15:0] length;
    } cmd_t;

    typedef enum logic [1:0] {
        WS_IDLE,
        WS_STEP,
        WS_LOOK,
        WS_EMIT
    } walk_state_t;

endpackage
`default_nettype wire

// ===== sv/fat12_chain_read_segmenter.sv =====
// Load requests: pass the classify register and queue head; the idle walk writes the table.
// Read requests: each cluster visited takes a step and, unless it ends the read, a table
// lookup; the last result comes from the emit state and waits while the output is busy.
// Rejected and too-long requests pass the classify register, the queue and the emit state.
// One request is walked at a time; the queue keeps accepting while the walk runs, until full.
// Reset (rst_n low, async) clears control state, sets data_base to 16896; table undefined.
`default_nettype none
module fat12_chain_read_segmenter (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // fat_byte_index, fat_byte, first_cluster, position, length, file_size
    input  wire logic [95:0] s_axis_tdata,
    // req_type
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // mem_addr, seg_len, dest_offset, bytes_read, new_position, zero pad
    output logic [95:0]      m_axis_tdata,
    // status
    output logic [1:0]       m_axis_tuser,
    output logic             m_axis_tlast
);

    logic             push;
    fat12s_pkg::cmd_t push_data;
    logic             fifo_full;
    logic             pop;
    fat12s_pkg::cmd_t pop_data;
    logic             fifo_empty;

    fat12s_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_data     (push_data),
        .fifo_full     (fifo_full)
    );

    fat12s_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (fifo_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (fifo_empty)
    );

    fat12s_walk u_walk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .fifo_empty    (fifo_empty),
        .cmd           (pop_data),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
`default_nettype wire

// ===== sv/fat12s_front.sv =====
`default_nettype none
module fat12s_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_axis_tvalid,
    output logic               s_axis_tready,
    input  wire logic [95:0]   s_axis_tdata,
    input  wire logic          s_axis_tuser,
    output logic               push,
    output fat12s_pkg::cmd_t   push_data,
    input  wire logic          fifo_full
);

    logic             cmd_valid_reg;
    logic             cmd_valid_next;
    fat12s_pkg::cmd_t cmd_reg;
    fat12s_pkg::cmd_t cmd_next;

    logic [12:0] fat_idx;
    logic [7:0]  fat_byte;
    logic [11:0] first_cluster;
    logic [20:0] position;
    logic [20:0] length;
    logic [20:0] file_size;
    logic [21:0] end_pos;
    logic [21:0] span;
    logic        bad_req;
    logic        too_long;
    logic        accept;
    logic        keep;

    assign fat_idx       = s_axis_tdata[12:0];
    assign fat_byte      = s_axis_tdata[20:13];
    assign first_cluster = s_axis_tdata[32:21];
    assign position      = s_axis_tdata[53:33];
    assign length        = s_axis_tdata[74:54];
    assign file_size     = s_axis_tdata[95:75];

    assign end_pos  = {1'b0, position} + {1'b0, length};
    assign bad_req  = (length == 21'd0) || (end_pos > {1'b0, file_size});
    // segment count exceeds the limit iff in-cluster offset plus length passes the limit
    assign span     = {13'd0, position[8:0]} + {1'b0, length};
    assign too_long = span > 22'(fat12s_pkg::SEG_LIMIT);

    assign push          = cmd_valid_reg && !fifo_full;
    assign push_data     = cmd_reg;
    assign s_axis_tready = !cmd_valid_reg || !fifo_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        cmd_next          = cmd_reg;
        cmd_next.fat_idx  = fat_idx;
        cmd_next.fat_byte = fat_byte;
        cmd_next.cluster  = first_cluster;
        cmd_next.position = position;
        cmd_next.length   = length[15:0];
        keep              = 1'b1;
        if (s_axis_tuser == fat12s_pkg::REQ_LOAD)
        begin
            cmd_next.kind = fat12s_pkg::CMD_LOAD;
            keep          = {1'b0, fat_idx} < 14'(fat12s_pkg::FAT_BYTES);
        end
        else if (bad_req)
        begin
            cmd_next.kind = fat12s_pkg::CMD_REJECT;
        end
        else if (too_long)
        begin
            cmd_next.kind = fat12s_pkg::CMD_TOOLONG;
        end
        else
        begin
            cmd_next.kind = fat12s_pkg::CMD_READ;
        end
    end

    always_comb
    begin
        cmd_valid_next = cmd_valid_reg;
        if (push)
        begin
            cmd_valid_next = 1'b0;
        end
        if (accept)
        begin
            cmd_valid_next = keep;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fat12s_fifo.sv =====
`default_nettype none
module fat12s_fifo (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire fat12s_pkg::cmd_t push_data,
    output logic                  full,
    input  wire logic             pop,
    output fat12s_pkg::cmd_t      pop_data,
    output logic                  empty
);

    localparam int PW = $clog2(fat12s_pkg::CMD_FIFO_DEPTH);
    localparam int CW = PW + 1;

    fat12s_pkg::cmd_t slots[fat12s_pkg::CMD_FIFO_DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          do_push;
    logic          do_pop;

    assign full     = count_reg == CW'(fat12s_pkg::CMD_FIFO_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

// ===== sv/fat12s_walk.sv =====
`default_nettype none
module fat12s_walk (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_wr_en,
    input  wire logic [31:0]      cfg_wr_data,
    input  wire logic             fifo_empty,
    input  wire fat12s_pkg::cmd_t cmd,
    output logic                  pop,
    output logic                  m_axis_tvalid,
    input  wire logic             m_axis_tready,
    output logic [95:0]           m_axis_tdata,
    output logic [1:0]            m_axis_tuser,
    output logic                  m_axis_tlast
);

    localparam int BAW = fat12s_pkg::BANK_AW;
    localparam int OW  = fat12s_pkg::OFF_W;

    fat12s_pkg::walk_state_t state_reg;
    fat12s_pkg::walk_state_t state_next;

    logic [31:0] data_base_reg;

    logic [11:0] cl_reg, cl_next;
    logic [20:0] pos_reg, pos_next;
    logic [15:0] rem_reg, rem_next;
    logic [15:0] rd_reg, rd_next;
    logic [20:0] position_reg, position_next;
    logic        has_seg_reg, has_seg_next;
    fat12s_pkg::status_t fin_status_reg, fin_status_next;
    logic [31:0] seg_addr_reg, seg_addr_next;
    logic [9:0]  seg_len_reg, seg_len_next;
    logic [14:0] seg_dst_reg, seg_dst_next;

    logic                out_valid_reg;
    fat12s_pkg::status_t out_status_reg;
    logic [31:0]         out_addr_reg;
    logic [9:0]          out_len_reg;
    logic [14:0]         out_dst_reg;
    logic [15:0]         out_rd_reg;
    logic [20:0]         out_np_reg;
    logic                out_last_reg;

    logic                emit;
    fat12s_pkg::status_t emit_status;
    logic [31:0]         emit_addr;
    logic [9:0]          emit_len;
    logic [14:0]         emit_dst;
    logic [15:0]         emit_rd;
    logic [20:0]         emit_np;
    logic                emit_last;
    logic                out_free;

    logic [7:0] even_mem[fat12s_pkg::BANK_DEPTH];
    logic [7:0] odd_mem[fat12s_pkg::BANK_DEPTH];
    logic [7:0] even_q_reg;
    logic [7:0] odd_q_reg;
    logic       off_lsb_reg;
    logic       lo_oob_reg;
    logic       hi_oob_reg;
    logic       mem_we;
    logic       mem_re;

    logic [OW-1:0]  off;
    logic [OW:0]    off_hi;
    logic [BAW-1:0] even_addr;
    logic [BAW-1:0] odd_addr;
    logic [7:0]     lo_byte;
    logic [7:0]     hi_byte;
    logic [15:0]    fat_word;
    logic [11:0]    entry;
    logic           chain_end;

    logic [31:0] cl_rel;
    logic [9:0]  room;
    logic [9:0]  take;
    logic        skip;
    logic        final_seg;

    assign out_free = !out_valid_reg || m_axis_tready;

    // packed FAT12: entry n lives at byte n*3/2, high nibble view for odd n
    assign off       = OW'({1'b0, cl_reg} + {2'b0, cl_reg[11:1]});
    assign off_hi    = {1'b0, off} + 1'b1;
    assign odd_addr  = off[OW-1:1];
    assign even_addr = off[0] ? off[OW-1:1] + 1'b1 : off[OW-1:1];

    assign lo_byte   = lo_oob_reg ? 8'hFF : (off_lsb_reg ? odd_q_reg : even_q_reg);
    assign hi_byte   = hi_oob_reg ? 8'hFF : (off_lsb_reg ? even_q_reg : odd_q_reg);
    assign fat_word  = {hi_byte, lo_byte};
    assign entry     = cl_reg[0] ? fat_word[15:4] : fat_word[11:0];
    assign chain_end = entry >= fat12s_pkg::CHAIN_END;

    assign skip      = pos_reg >= 21'(fat12s_pkg::CLUSTER_BYTES);
    assign room      = 10'(fat12s_pkg::CLUSTER_BYTES) - {1'b0, pos_reg[8:0]};
    assign take      = (rem_reg < {6'd0, room}) ? rem_reg[9:0] : room;
    assign final_seg = rem_reg == {6'd0, take};
    assign cl_rel    = {20'd0, cl_reg} - 32'd2;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            fat12s_pkg::WS_IDLE:
            begin
                if (!fifo_empty)
                begin
                    case (cmd.kind)
                        fat12s_pkg::CMD_LOAD: state_next = fat12s_pkg::WS_IDLE;
                        fat12s_pkg::CMD_READ: state_next = fat12s_pkg::WS_STEP;
                        default:              state_next = fat12s_pkg::WS_EMIT;
                    endcase
                end
            end
            fat12s_pkg::WS_STEP:
            begin
                if (!skip && final_seg)
                begin
                    state_next = fat12s_pkg::WS_EMIT;
                end
                else
                begin
                    state_next = fat12s_pkg::WS_LOOK;
                end
            end
            fat12s_pkg::WS_LOOK:
            begin
                if (chain_end)
                begin
                    state_next = fat12s_pkg::WS_EMIT;
                end
                else if (!has_seg_reg || out_free)
                begin
                    state_next = fat12s_pkg::WS_STEP;
                end
            end
            fat12s_pkg::WS_EMIT:
            begin
                if (out_free)
                begin
                    state_next = fat12s_pkg::WS_IDLE;
                end
            end
            default:
            begin
                state_next = fat12s_pkg::WS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop             = 1'b0;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        emit            = 1'b0;
        emit_status     = fat12s_pkg::STAT_SEG;
        emit_addr       = seg_addr_reg;
        emit_len        = seg_len_reg;
        emit_dst        = seg_dst_reg;
        emit_rd         = 16'd0;
        emit_np         = 21'd0;
        emit_last       = 1'b0;
        cl_next         = cl_reg;
        pos_next        = pos_reg;
        rem_next        = rem_reg;
        rd_next         = rd_reg;
        position_next   = position_reg;
        has_seg_next    = has_seg_reg;
        fin_status_next = fin_status_reg;
        seg_addr_next   = seg_addr_reg;
        seg_len_next    = seg_len_reg;
        seg_dst_next    = seg_dst_reg;
        case (state_reg)
            fat12s_pkg::WS_IDLE:
            begin
                if (!fifo_empty)
                begin
                    pop           = 1'b1;
                    cl_next       = cmd.cluster;
                    pos_next      = cmd.position;
                    rem_next      = cmd.length;
                    rd_next       = 16'd0;
                    position_next = cmd.position;
                    has_seg_next  = 1'b0;
                    case (cmd.kind)
                        fat12s_pkg::CMD_LOAD:    mem_we          = 1'b1;
                        fat12s_pkg::CMD_REJECT:  fin_status_next = fat12s_pkg::STAT_REJECT;
                        fat12s_pkg::CMD_TOOLONG: fin_status_next = fat12s_pkg::STAT_TOOLONG;
                        default:                 fin_status_next = fin_status_reg;
                    endcase
                end
            end
            fat12s_pkg::WS_STEP:
            begin
                if (skip)
                begin
                    pos_next = pos_reg - 21'(fat12s_pkg::CLUSTER_BYTES);
                    mem_re   = 1'b1;
                end
                else
                begin
                    seg_addr_next = {cl_rel[22:0], 9'd0} + data_base_reg
                                    + {23'd0, pos_reg[8:0]};
                    seg_len_next  = take;
                    seg_dst_next  = rd_reg[14:0];
                    rd_next       = rd_reg + {6'd0, take};
                    rem_next      = rem_reg - {6'd0, take};
                    pos_next      = 21'd0;
                    has_seg_next  = 1'b1;
                    mem_re        = !final_seg;
                end
            end
            fat12s_pkg::WS_LOOK:
            begin
                if (chain_end)
                begin
                    fin_status_next = fat12s_pkg::STAT_CHAIN_END;
                end
                else if (!has_seg_reg || out_free)
                begin
                    cl_next      = entry;
                    has_seg_next = 1'b0;
                    emit         = has_seg_reg;
                end
            end
            fat12s_pkg::WS_EMIT:
            begin
                if (out_free)
                begin
                    emit         = 1'b1;
                    emit_last    = 1'b1;
                    has_seg_next = 1'b0;
                    if (has_seg_reg)
                    begin
                        emit_rd = rd_reg;
                        emit_np = position_reg + {5'd0, rd_reg};
                    end
                    else
                    begin
                        emit_status = fin_status_reg;
                        emit_addr   = 32'd0;
                        emit_len    = 10'd0;
                        emit_dst    = 15'd0;
                        emit_np     = position_reg;
                    end
                end
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fat12s_pkg::WS_IDLE;
            data_base_reg <= fat12s_pkg::DATA_BASE_RST;
            has_seg_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            has_seg_reg <= has_seg_next;
            if (cfg_wr_en)
            begin
                data_base_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cl_reg         <= cl_next;
        pos_reg        <= pos_next;
        rem_reg        <= rem_next;
        rd_reg         <= rd_next;
        position_reg   <= position_next;
        fin_status_reg <= fin_status_next;
        seg_addr_reg   <= seg_addr_next;
        seg_len_reg    <= seg_len_next;
        seg_dst_reg    <= seg_dst_next;
        if (emit)
        begin
            out_status_reg <= emit_status;
            out_addr_reg   <= emit_addr;
            out_len_reg    <= emit_len;
            out_dst_reg    <= emit_dst;
            out_rd_reg     <= emit_rd;
            out_np_reg     <= emit_np;
            out_last_reg   <= emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            if (cmd.fat_idx[0])
            begin
                odd_mem[cmd.fat_idx[OW-1:1]] <= cmd.fat_byte;
            end
            else
            begin
                even_mem[cmd.fat_idx[OW-1:1]] <= cmd.fat_byte;
            end
        end
        if (mem_re)
        begin
            even_q_reg  <= even_mem[even_addr];
            odd_q_reg   <= odd_mem[odd_addr];
            off_lsb_reg <= off[0];
            lo_oob_reg  <= {1'b0, off} >= (OW + 1)'(fat12s_pkg::FAT_BYTES);
            hi_oob_reg  <= off_hi >= (OW + 1)'(fat12s_pkg::FAT_BYTES);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {2'd0, out_np_reg, out_rd_reg, out_dst_reg, out_len_reg, out_addr_reg};

    a_look_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fat12s_pkg::WS_LOOK |->
            ($past(state_reg) == fat12s_pkg::WS_STEP || $past(state_reg) == fat12s_pkg::WS_LOOK))
        else $error("lookup state entered without a fetch");

    a_look_has_work: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fat12s_pkg::WS_LOOK |-> rem_reg != 16'd0)
        else $error("chain lookup with nothing left to read");

    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg != fat12s_pkg::STAT_SEG |-> out_last_reg)
        else $error("error result not marked last");

    a_step_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == fat12s_pkg::WS_STEP |-> !has_seg_reg)
        else $error("new cluster step with an unsent segment");

endmodule
`default_nettype wire
